// ===== design/msc_pkg.sv =====
`timescale 1ns / 1ps

package msc_pkg;

	localparam int PIX_W   = 8;
	localparam int MEAN_W  = 12;
	localparam int DIFF_W  = 13;
	localparam int SQ_W    = 2 * DIFF_W;
	localparam int COEF_W  = 32;
	localparam int TERM_W  = SQ_W + COEF_W;
	localparam int SUM_W   = 62;
	localparam int DIST_W  = 32;
	localparam int FRAC_SH = 24;
	localparam int CFG_W   = 36;
	localparam int IDX_W   = 3;

	localparam logic [PIX_W-1:0]  MASK_SKIN  = 8'd255;
	localparam logic [PIX_W-1:0]  MASK_OTHER = 8'd0;
	localparam logic [DIST_W-1:0] THR_RESET  = 32'd16384;

	typedef enum logic [IDX_W-1:0] {
		REG_MEAN      = 3'd0,
		REG_ICOV_BB   = 3'd1,
		REG_ICOV_GG   = 3'd2,
		REG_ICOV_RR   = 3'd3,
		REG_ICOV_BG   = 3'd4,
		REG_ICOV_BR   = 3'd5,
		REG_ICOV_GR   = 3'd6,
		REG_THRESHOLD = 3'd7
	} reg_idx_t;

	typedef logic signed [DIFF_W-1:0] diff_t;
	typedef logic signed [SQ_W-1:0]   sq_t;
	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic signed [TERM_W-1:0] term_t;
	typedef logic signed [SUM_W-1:0]  sum_t;

	// model coefficients seen by the datapath
	typedef struct packed {
		logic [MEAN_W-1:0] mean_b;
		logic [MEAN_W-1:0] mean_g;
		logic [MEAN_W-1:0] mean_r;
		coef_t             bb;
		coef_t             gg;
		coef_t             rr;
		coef_t             bg;
		coef_t             br;
		coef_t             gr;
	} model_t;

endpackage

// ===== design/mahalanobis_skin_pixel_classifier_top.sv =====
`timescale 1ns / 1ps

// Skin pixel classifier by squared Mahalanobis distance to a configured color model.
// Pixel request: drive blue/green/red with start high; it is taken on any edge where
// busy is low. busy never rises, so a new pixel may enter on every clock.
// Result: done is high for one cycle with mask (255 skin, 0 not) and dist_sq (Q24.8).
// Throughput is one pixel per clock; each pixel passes the six-stage arithmetic pipeline
// (difference, channel products, coefficient products, two adder stages, clamp)
// and then the output register that does the threshold compare.
// The receiver cannot stall: done is a strobe and must be captured when seen.
// Configuration: cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready is always high.
// Index 0 mean (three Q8.4), 1..6 inverse covariance (bb, gg, rr, bg, br, gr,
// signed Q8.24), 7 squared threshold (Q24.8). Write only while no pixel is in flight.
// Reset (arst_n low) clears the pipeline valids and done, zeroes the model and sets
// the threshold to 64.0.
module mahalanobis_skin_pixel_classifier_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [msc_pkg::PIX_W-1:0]     blue,
	input  logic [msc_pkg::PIX_W-1:0]     green,
	input  logic [msc_pkg::PIX_W-1:0]     red,
	output logic                          done,
	output logic [msc_pkg::PIX_W-1:0]     mask,
	output logic [msc_pkg::DIST_W-1:0]    dist_sq,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [msc_pkg::IDX_W-1:0]     cfg_index,
	input  logic [msc_pkg::CFG_W-1:0]     cfg_data
);

	msc_pkg::model_t             model_q;
	logic [msc_pkg::DIST_W-1:0]  thr_q;
	logic                        q_valid;
	logic [msc_pkg::DIST_W-1:0]  q_dist;
	logic                        done_q;
	logic [msc_pkg::PIX_W-1:0]   mask_q;
	logic [msc_pkg::DIST_W-1:0]  dist_q;
	msc_pkg::coef_t              cfg_coef;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign cfg_coef  = msc_pkg::coef_t'(cfg_data[msc_pkg::COEF_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			model_q <= '0;
			thr_q   <= msc_pkg::THR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (msc_pkg::reg_idx_t'(cfg_index))
				msc_pkg::REG_MEAN: begin
					model_q.mean_b <= cfg_data[msc_pkg::MEAN_W-1:0];
					model_q.mean_g <= cfg_data[2*msc_pkg::MEAN_W-1:msc_pkg::MEAN_W];
					model_q.mean_r <= cfg_data[3*msc_pkg::MEAN_W-1:2*msc_pkg::MEAN_W];
				end
				msc_pkg::REG_ICOV_BB:   model_q.bb <= cfg_coef;
				msc_pkg::REG_ICOV_GG:   model_q.gg <= cfg_coef;
				msc_pkg::REG_ICOV_RR:   model_q.rr <= cfg_coef;
				msc_pkg::REG_ICOV_BG:   model_q.bg <= cfg_coef;
				msc_pkg::REG_ICOV_BR:   model_q.br <= cfg_coef;
				msc_pkg::REG_ICOV_GR:   model_q.gr <= cfg_coef;
				msc_pkg::REG_THRESHOLD: thr_q <= cfg_data[msc_pkg::DIST_W-1:0];
				default: ;
			endcase
		end
	end

	msc_quad u_quad (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.blue      (blue),
		.green     (green),
		.red       (red),
		.model     (model_q),
		.out_valid (q_valid),
		.dist_sq   (q_dist)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		dist_q <= q_dist;
		mask_q <= (q_dist <= thr_q) ? msc_pkg::MASK_SKIN : msc_pkg::MASK_OTHER;
	end

	assign done    = done_q;
	assign mask    = mask_q;
	assign dist_sq = dist_q;

endmodule

// ===== design/msc_quad.sv =====
`timescale 1ns / 1ps

module msc_quad (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [msc_pkg::PIX_W-1:0]     blue,
	input  logic [msc_pkg::PIX_W-1:0]     green,
	input  logic [msc_pkg::PIX_W-1:0]     red,
	input  msc_pkg::model_t               model,
	output logic                          out_valid,
	output logic [msc_pkg::DIST_W-1:0]    dist_sq
);

	logic                  v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	msc_pkg::diff_t        db_s1, dg_s1, dr_s1;
	msc_pkg::sq_t          pbb_s2, pgg_s2, prr_s2, pbg_s2, pbr_s2, pgr_s2;
	msc_pkg::term_t        tbb_s3, tgg_s3, trr_s3, tbg_s3, tbr_s3, tgr_s3;
	msc_pkg::sum_t         a_s4, b_s4, c_s4;
	msc_pkg::sum_t         sum_s5;
	logic [msc_pkg::DIST_W-1:0] dist_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		// pixel*16 - mean, both zero-extended to 13 bits
		db_s1 <= msc_pkg::diff_t'({1'b0, blue,  4'b0000}) - msc_pkg::diff_t'({1'b0, model.mean_b});
		dg_s1 <= msc_pkg::diff_t'({1'b0, green, 4'b0000}) - msc_pkg::diff_t'({1'b0, model.mean_g});
		dr_s1 <= msc_pkg::diff_t'({1'b0, red,   4'b0000}) - msc_pkg::diff_t'({1'b0, model.mean_r});

		pbb_s2 <= msc_pkg::sq_t'(db_s1) * msc_pkg::sq_t'(db_s1);
		pgg_s2 <= msc_pkg::sq_t'(dg_s1) * msc_pkg::sq_t'(dg_s1);
		prr_s2 <= msc_pkg::sq_t'(dr_s1) * msc_pkg::sq_t'(dr_s1);
		pbg_s2 <= msc_pkg::sq_t'(db_s1) * msc_pkg::sq_t'(dg_s1);
		pbr_s2 <= msc_pkg::sq_t'(db_s1) * msc_pkg::sq_t'(dr_s1);
		pgr_s2 <= msc_pkg::sq_t'(dg_s1) * msc_pkg::sq_t'(dr_s1);

		tbb_s3 <= msc_pkg::term_t'(pbb_s2) * msc_pkg::term_t'(model.bb);
		tgg_s3 <= msc_pkg::term_t'(pgg_s2) * msc_pkg::term_t'(model.gg);
		trr_s3 <= msc_pkg::term_t'(prr_s2) * msc_pkg::term_t'(model.rr);
		tbg_s3 <= msc_pkg::term_t'(pbg_s2) * msc_pkg::term_t'(model.bg);
		tbr_s3 <= msc_pkg::term_t'(pbr_s2) * msc_pkg::term_t'(model.br);
		tgr_s3 <= msc_pkg::term_t'(pgr_s2) * msc_pkg::term_t'(model.gr);

		// cross terms count twice
		a_s4 <= msc_pkg::sum_t'(tbb_s3) + msc_pkg::sum_t'(tgg_s3);
		b_s4 <= msc_pkg::sum_t'(trr_s3) + (msc_pkg::sum_t'(tbg_s3) <<< 1);
		c_s4 <= (msc_pkg::sum_t'(tbr_s3) <<< 1) + (msc_pkg::sum_t'(tgr_s3) <<< 1);

		sum_s5 <= a_s4 + b_s4 + c_s4;

		// clamp negative to 0, Q.32 -> Q24.8, saturate
		if (sum_s5[msc_pkg::SUM_W-1]) begin
			dist_s6 <= '0;
		end else if (|sum_s5[msc_pkg::SUM_W-2:msc_pkg::FRAC_SH+msc_pkg::DIST_W]) begin
			dist_s6 <= '1;
		end else begin
			dist_s6 <= sum_s5[msc_pkg::FRAC_SH+msc_pkg::DIST_W-1:msc_pkg::FRAC_SH];
		end
	end

	assign out_valid = v_s6;
	assign dist_sq   = dist_s6;

endmodule

// ===== tb/sv/skin_mask_checker.sv =====
`timescale 1ns / 1ps

module skin_mask_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          busy,
	input  logic [msc_pkg::PIX_W-1:0]     blue,
	input  logic [msc_pkg::PIX_W-1:0]     green,
	input  logic [msc_pkg::PIX_W-1:0]     red,
	input  logic                          done,
	input  logic [msc_pkg::PIX_W-1:0]     mask,
	input  logic [msc_pkg::DIST_W-1:0]    dist_sq,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [msc_pkg::IDX_W-1:0]     cfg_index,
	input  logic [msc_pkg::CFG_W-1:0]     cfg_data,
	output int                            mismatches,
	output int                            outstanding
);
	import msc_pkg::*;

	typedef struct packed {
		logic [PIX_W-1:0]  b;
		logic [PIX_W-1:0]  g;
		logic [PIX_W-1:0]  r;
		logic [PIX_W-1:0]  mask;
		logic [DIST_W-1:0] dsq;
	} pixel_verdict_t;

	model_t              color_model;
	logic [DIST_W-1:0]   dist_limit;
	pixel_verdict_t      verdict_q[$];
	pixel_verdict_t      oldest;

	// exact quadratic form, then clamp at zero, truncate to Q24.8 and saturate
	function automatic pixel_verdict_t classify_pixel(input model_t m,
			input logic [DIST_W-1:0] limit, input logic [PIX_W-1:0] b,
			input logic [PIX_W-1:0] g, input logic [PIX_W-1:0] r);
		longint         db;
		longint         dg;
		longint         dr;
		longint         acc;
		logic [63:0]    scaled;
		pixel_verdict_t v;
		db = longint'(b) * 16 - longint'(m.mean_b);
		dg = longint'(g) * 16 - longint'(m.mean_g);
		dr = longint'(r) * 16 - longint'(m.mean_r);
		acc = db * db * longint'(m.bb)
			+ dg * dg * longint'(m.gg)
			+ dr * dr * longint'(m.rr)
			+ 2 * (db * dg * longint'(m.bg))
			+ 2 * (db * dr * longint'(m.br))
			+ 2 * (dg * dr * longint'(m.gr));
		if (acc < 0)
			scaled = '0;
		else
			scaled = 64'(acc) >> FRAC_SH;
		if (scaled > 64'h0000_0000_FFFF_FFFF)
			scaled = 64'h0000_0000_FFFF_FFFF;
		v.b = b;
		v.g = g;
		v.r = r;
		v.dsq = scaled[DIST_W-1:0];
		v.mask = (v.dsq <= limit) ? MASK_SKIN : MASK_OTHER;
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_model = '0;
			dist_limit = THR_RESET;
			verdict_q.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (done) begin
				if (verdict_q.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: result with no pixel in flight: mask %0d dist_sq 0x%08h",
							$time, mask, dist_sq);
					mismatches++;
				end else begin
					oldest = verdict_q.pop_front();
					if (mask !== oldest.mask || dist_sq !== oldest.dsq) begin
						if (mismatches < 10)
							$display({"%0t: pixel b=%0d g=%0d r=%0d: expected mask %0d ",
								"dist_sq 0x%08h, got mask %0d dist_sq 0x%08h"},
								$time, oldest.b, oldest.g, oldest.r, oldest.mask,
								oldest.dsq, mask, dist_sq);
						mismatches++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (reg_idx_t'(cfg_index))
					REG_MEAN: begin
						color_model.mean_b = cfg_data[11:0];
						color_model.mean_g = cfg_data[23:12];
						color_model.mean_r = cfg_data[35:24];
					end
					REG_ICOV_BB:   color_model.bb = cfg_data[COEF_W-1:0];
					REG_ICOV_GG:   color_model.gg = cfg_data[COEF_W-1:0];
					REG_ICOV_RR:   color_model.rr = cfg_data[COEF_W-1:0];
					REG_ICOV_BG:   color_model.bg = cfg_data[COEF_W-1:0];
					REG_ICOV_BR:   color_model.br = cfg_data[COEF_W-1:0];
					REG_ICOV_GR:   color_model.gr = cfg_data[COEF_W-1:0];
					REG_THRESHOLD: dist_limit = cfg_data[DIST_W-1:0];
					default: ;
				endcase
			end
			if (start && !busy)
				verdict_q.push_back(classify_pixel(color_model, dist_limit, blue, green, red));
			outstanding = verdict_q.size();
		end
	end

endmodule

// ===== tb/sv/tb_mahalanobis_skin_pixel_classifier_top.sv =====
`timescale 1ns / 1ps

module tb_mahalanobis_skin_pixel_classifier_top;
	import msc_pkg::*;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b1;
	logic                  start = 1'b0;
	logic [PIX_W-1:0]      blue = '0;
	logic [PIX_W-1:0]      green = '0;
	logic [PIX_W-1:0]      red = '0;
	logic                  cfg_valid = 1'b0;
	logic [IDX_W-1:0]      cfg_index = '0;
	logic [CFG_W-1:0]      cfg_data = '0;
	logic                  busy;
	logic                  done;
	logic                  cfg_ready;
	logic [PIX_W-1:0]      mask;
	logic [DIST_W-1:0]     dist_sq;
	int                    mismatches;
	int                    outstanding;

	int                    burst_left = 0;
	bit                    calm = 1'b0;
	int                    pixels_sent = 0;
	int                    models_loaded = 0;
	logic [CFG_W-1:0]      cur_mean = '0;

	always #5 clk = ~clk;

	mahalanobis_skin_pixel_classifier_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.blue      (blue),
		.green     (green),
		.red       (red),
		.done      (done),
		.mask      (mask),
		.dist_sq   (dist_sq),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	skin_mask_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.blue        (blue),
		.green       (green),
		.red         (red),
		.done        (done),
		.mask        (mask),
		.dist_sq     (dist_sq),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// leaves cfg_valid high so back-to-back writes need no extra NBA
	task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic load_model(input logic [CFG_W-1:0] mean, input logic [31:0] bb,
			input logic [31:0] gg, input logic [31:0] rr, input logic [31:0] bg,
			input logic [31:0] br, input logic [31:0] gr, input logic [31:0] limit);
		write_reg(REG_MEAN, mean);
		write_reg(REG_ICOV_BB, {4'h0, bb});
		write_reg(REG_ICOV_GG, {4'h0, gg});
		write_reg(REG_ICOV_RR, {4'h0, rr});
		write_reg(REG_ICOV_BG, {4'h0, bg});
		write_reg(REG_ICOV_BR, {4'h0, br});
		write_reg(REG_ICOV_GR, {4'h0, gr});
		write_reg(REG_THRESHOLD, {4'h0, limit});
		cfg_valid <= 1'b0;
		cur_mean = mean;
		models_loaded++;
	endtask

	task automatic push_pixel(input logic [PIX_W-1:0] b, input logic [PIX_W-1:0] g,
			input logic [PIX_W-1:0] r);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = (calm || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		start <= 1'b1;
		blue <= b;
		green <= g;
		red <= r;
		do @(posedge clk); while (busy);
		pixels_sent++;
	endtask

	// hold off until every request has come back, then let the pipeline settle
	task automatic drain_pipeline();
		start <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		repeat (10) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_coef(input int style, input bit on_diag);
		logic [31:0] c;
		case (style)
			0: c = on_diag ? $urandom_range(0, 32'h0040_0000)
				: $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
			1: c = $urandom();
			default: begin
				case ($urandom_range(0, 5))
					0: c = 32'h7FFF_FFFF;
					1: c = 32'h8000_0000;
					2: c = 32'h0000_0000;
					3: c = 32'h0000_0001;
					4: c = 32'hFFFF_FFFF;
					default: c = 32'h0100_0000;
				endcase
			end
		endcase
		return c;
	endfunction

	function automatic logic [31:0] pick_limit(input int style);
		case (style)
			0: return $urandom_range(0, 32'h0004_0000);
			1: return $urandom();
			2: return 32'h0000_0000;
			default: return 32'hFFFF_FFFF;
		endcase
	endfunction

	function automatic logic [PIX_W-1:0] near_channel(input logic [MEAN_W-1:0] m);
		int v;
		v = int'(m >> 4) + int'($urandom_range(0, 40)) - 20;
		if (v < 0)
			v = 0;
		if (v > 255)
			v = 255;
		return v[PIX_W-1:0];
	endfunction

	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		logic [MEAN_W-1:0] mb;
		logic [MEAN_W-1:0] mg;
		logic [MEAN_W-1:0] mr;
		logic [PIX_W-1:0]  pb;
		logic [PIX_W-1:0]  pg;
		logic [PIX_W-1:0]  pr;
		int                cstyle;
		// falling edge once every process waits, so the asynchronous resets fire
		arst_n <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset model: zero form, every pixel is skin
		push_pixel(8'd0, 8'd0, 8'd0);
		push_pixel(8'd255, 8'd255, 8'd255);
		push_pixel(8'd8, 8'd200, 8'd17);
		drain_pipeline();

		// unit blue weight: dist_sq raw = 256*b^2, so b=8 sits exactly on the default limit
		load_model('0, 32'h0100_0000, '0, '0, '0, '0, '0, THR_RESET);
		push_pixel(8'd8, 8'd0, 8'd0);
		push_pixel(8'd9, 8'd0, 8'd0);
		push_pixel(8'd7, 8'd99, 8'd250);
		push_pixel(8'd0, 8'd255, 8'd255);
		drain_pipeline();

		// negative form clamps to zero; limit zero still accepts zero
		load_model({CFG_W{1'b1}}, 32'h8000_0000, '0, '0, '0, '0, '0, '0);
		push_pixel(8'd0, 8'd0, 8'd0);
		push_pixel(8'd255, 8'd255, 8'd255);
		drain_pipeline();

		// saturated distance only passes at the all-ones limit
		load_model('0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		push_pixel(8'd255, 8'd255, 8'd255);
		push_pixel(8'd0, 8'd0, 8'd0);
		drain_pipeline();
		load_model('0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFE);
		push_pixel(8'd255, 8'd255, 8'd255);
		push_pixel(8'd1, 8'd0, 8'd0);
		drain_pipeline();

		// strongly negative cross terms against maximal diagonal
		load_model('0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, THR_RESET);
		push_pixel(8'd255, 8'd255, 8'd0);
		push_pixel(8'd255, 8'd0, 8'd255);
		push_pixel(8'd0, 8'd255, 8'd255);
		push_pixel(8'd255, 8'd255, 8'd255);
		push_pixel(8'd128, 8'd64, 8'd32);
		drain_pipeline();

		// plausible skin model with fractional means
		load_model({12'd2892, 12'd2244, 12'd1928}, 32'h0002_8F5C, 32'h0002_8F5C,
			32'h0002_8F5C, 32'hFFFF_8000, 32'hFFFF_8000, 32'hFFFF_8000, THR_RESET);
		push_pixel(8'd120, 8'd140, 8'd180);
		push_pixel(8'd121, 8'd140, 8'd181);
		push_pixel(8'd0, 8'd0, 8'd0);
		push_pixel(8'd255, 8'd255, 8'd255);
		push_pixel(8'd60, 8'd200, 8'd90);
		drain_pipeline();

		for (int p = 0; p < 7; p++) begin
			calm = (p == 3);
			cstyle = (p < 3) ? 0 : $urandom_range(0, 2);
			mb = $urandom();
			mg = $urandom();
			mr = $urandom();
			load_model({mr, mg, mb}, pick_coef(cstyle, 1'b1), pick_coef(cstyle, 1'b1),
				pick_coef(cstyle, 1'b1), pick_coef(cstyle, 1'b0), pick_coef(cstyle, 1'b0),
				pick_coef(cstyle, 1'b0),
				pick_limit((cstyle == 0) ? 0 : $urandom_range(0, 3)));
			for (int i = 0; i < 100; i++) begin
				case ($urandom_range(0, 3))
					2: begin
						pb = near_channel(cur_mean[11:0]);
						pg = near_channel(cur_mean[23:12]);
						pr = near_channel(cur_mean[35:24]);
					end
					3: begin
						pb = $urandom_range(0, 1) ? 8'hFF : 8'h00;
						pg = $urandom_range(0, 1) ? 8'hFF : 8'h00;
						pr = $urandom_range(0, 1) ? 8'hFF : 8'h00;
					end
					default: begin
						pb = $urandom();
						pg = $urandom();
						pr = $urandom();
					end
				endcase
				push_pixel(pb, pg, pr);
			end
			drain_pipeline();
		end

		$display("run: %0d pixels classified under %0d loaded color models", pixels_sent,
			models_loaded);
		$display("run: reset model, limit edge, negative clamp, saturation and random models");
		if (mismatches + outstanding == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/msc_pkg.sv
design/msc_quad.sv
design/mahalanobis_skin_pixel_classifier_top.sv
tb/sv/skin_mask_checker.sv
tb/sv/tb_mahalanobis_skin_pixel_classifier_top.sv
